/* design/assert_macros.svh */
// assertion macros used by the checker file of the accumulator
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ADDA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ADDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/adda_pkg.sv */
// shared types and constants of the attentional drift accumulator
// no dependencies; imported by the lane, merge and core modules
`default_nettype none

package adda_pkg;

   localparam int FRAC_BITS = 10;          // fixed point fraction bits
   localparam int EVID_W    = 24;          // evidence width
   localparam int DRIFT_W   = 16;
   localparam int THETA_W   = 11;
   localparam int PROD_W    = 27;          // drift * theta, signed
   localparam int DISC_W    = PROD_W - FRAC_BITS;
   localparam int SUM_W     = 26;          // evidence + increment + noise
   localparam int CNT_W     = 16;
   localparam int FIX_W     = 10;
   localparam int NUM_PORTS = 4;           // items carried on the ports
   localparam int CSR_AW    = 3;

   typedef logic [CSR_AW-1:0] csr_addr_type;

   localparam csr_addr_type CSR_DRIFT_A  = 3'd0;
   localparam csr_addr_type CSR_DRIFT_B  = 3'd1;
   localparam csr_addr_type CSR_DRIFT_C  = 3'd2;
   localparam csr_addr_type CSR_DRIFT_D  = 3'd3;
   localparam csr_addr_type CSR_THETA    = 3'd4;
   localparam csr_addr_type CSR_MAX_DUR  = 3'd5;
   localparam csr_addr_type CSR_BARRIER  = 3'd6;

   localparam logic [THETA_W-1:0] THETA_RESET   = 11'd1024;
   localparam logic [CNT_W-1:0]   MAX_DUR_RESET = 16'hFFFF;
   localparam logic [CNT_W-1:0]   BARRIER_RESET = 16'd1024;
   localparam logic [CNT_W-1:0]   CNT_MAX       = 16'hFFFF;
   localparam logic [FIX_W-1:0]   FIX_MAX       = 10'h3FF;

   // per-request lane control
   typedef struct packed {
      logic accept;   // request taken this cycle
      logic clear;    // trial start
      logic hold;     // trial already finished, freeze state
   } lane_ctrl_type;

endpackage

`default_nettype wire

/* design/adda_if.sv */
// request and response channel interfaces of the accumulator
// no dependencies
`default_nettype none

interface adda_req_if;
   logic               valid;
   logic               ready;
   logic               trial_start;
   logic        [1:0]  fix_item;
   logic               fix_first;
   logic               fix_last;
   logic signed [15:0] noise_a;
   logic signed [15:0] noise_b;
   logic signed [15:0] noise_c;
   logic signed [15:0] noise_d;

   modport source (output valid, trial_start, fix_item, fix_first, fix_last,
                   noise_a, noise_b, noise_c, noise_d, input ready);
   modport sink   (input valid, trial_start, fix_item, fix_first, fix_last,
                   noise_a, noise_b, noise_c, noise_d, output ready);
endinterface

interface adda_rsp_if;
   logic               valid;
   logic               ready;
   logic               done_res;
   logic               timed_out;
   logic        [1:0]  choice;
   logic        [15:0] rt_ms;
   logic        [9:0]  fixations;
   logic               last_fixated_chosen;
   logic signed [15:0] last_fixated_drift;
   logic        [15:0] dwell_a;
   logic        [15:0] dwell_b;
   logic        [15:0] dwell_c;
   logic        [15:0] dwell_d;

   modport source (output valid, done_res, timed_out, choice, rt_ms, fixations,
                   last_fixated_chosen, last_fixated_drift,
                   dwell_a, dwell_b, dwell_c, dwell_d, input ready);
   modport sink   (input valid, done_res, timed_out, choice, rt_ms, fixations,
                   last_fixated_chosen, last_fixated_drift,
                   dwell_a, dwell_b, dwell_c, dwell_d, output ready);
endinterface

`default_nettype wire

/* design/adda_lane.sv */
// one evidence lane: discounted drift, noise add, saturation, dwell counter
// depends on adda_pkg
`default_nettype none

module adda_lane (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire adda_pkg::lane_ctrl_type              ctrl,
   input  wire logic                                 fixated,
   input  wire logic signed [adda_pkg::DRIFT_W-1:0]  drift,
   input  wire logic        [adda_pkg::THETA_W-1:0]  theta,
   input  wire logic signed [adda_pkg::DRIFT_W-1:0]  noise,
   output logic signed      [adda_pkg::EVID_W-1:0]   ev_next,
   output logic             [adda_pkg::CNT_W-1:0]    dwell_next
);
   import adda_pkg::*;

   localparam logic signed [SUM_W-1:0] EvMax = SUM_W'(2**(EVID_W-1) - 1);
   localparam logic signed [SUM_W-1:0] EvMin = -SUM_W'(2**(EVID_W-1));

   logic signed [EVID_W-1:0] ev_ff, ev_cur;
   logic        [CNT_W-1:0]  dwell_ff, dwell_cur;
   logic signed [PROD_W-1:0] prod;
   logic signed [DISC_W-1:0] disc_ff, disc_in;
   logic signed [SUM_W-1:0]  inc, sum;

   // drift * theta depends on settings only, so it is kept registered
   assign prod    = PROD_W'(drift * $signed({1'b0, theta}));
   assign disc_in = DISC_W'(prod >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      disc_in_reg: disc_ff <= disc_in;
   end

   assign ev_cur    = ctrl.clear ? '0 : ev_ff;
   assign dwell_cur = ctrl.clear ? '0 : dwell_ff;

   assign inc = fixated ? SUM_W'(drift) : SUM_W'(disc_ff);
   assign sum = SUM_W'(ev_cur) + inc + SUM_W'(noise);

   always_comb begin
      if (ctrl.hold) begin
         ev_next = ev_cur;
      end else if (sum > EvMax) begin
         ev_next = EVID_W'(EvMax);
      end else if (sum < EvMin) begin
         ev_next = EVID_W'(EvMin);
      end else begin
         ev_next = EVID_W'(sum);
      end
   end

   always_comb begin
      if (!ctrl.hold && fixated && dwell_cur != CNT_MAX) begin
         dwell_next = dwell_cur + CNT_W'(1);
      end else begin
         dwell_next = dwell_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff    <= '0;
         dwell_ff <= '0;
      end else if (ctrl.accept) begin
         ev_ff    <= ev_next;
         dwell_ff <= dwell_next;
      end
   end

endmodule

`default_nettype wire

/* design/adda_merge.sv */
// merge stage: lowest-index maximum of the lanes and barrier lead check
// depends on adda_pkg
`default_nettype none

module adda_merge #(
   parameter int NUM_ITEMS = 4
) (
   input  wire logic signed [adda_pkg::EVID_W-1:0] ev [NUM_ITEMS],
   input  wire logic        [adda_pkg::CNT_W-1:0]  barrier,
   output logic             [$clog2(NUM_ITEMS)-1:0] leader,
   output logic                                     decided
);
   import adda_pkg::*;

   localparam int LW = $clog2(NUM_ITEMS);

   logic signed [EVID_W-1:0] best_val;
   logic signed [EVID_W:0]   lead [NUM_ITEMS];

   // strict compare keeps the lowest index on ties
   always_comb begin
      best_val = ev[0];
      leader   = '0;
      for (int i = 1; i < NUM_ITEMS; i++) begin
         if (ev[i] > best_val) begin
            best_val = ev[i];
            leader   = LW'(i);
         end
      end
   end

   always_comb begin
      decided = 1'b1;
      for (int k = 0; k < NUM_ITEMS; k++) begin
         lead[k] = (EVID_W+1)'(best_val) - (EVID_W+1)'(ev[k]);
         if (LW'(k) != leader && lead[k] < $signed({9'b0, barrier})) begin
            decided = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

/* design/attentional_drift_accumulator_core.sv */
// top level of the attentional drift accumulator: settings, trial counters,
// response register; depends on adda_pkg, adda_if, adda_lane, adda_merge
`default_nettype none

// Race of NUM_ITEMS evidence lanes, one simulated millisecond per request.
// Every request yields exactly one response. Throughput is one request per
// clock unless the port stalls: the lanes add drift and noise, saturate to
// 24 bits, and the merge stage picks the lowest-index leader and checks the
// barrier, all within the cycle that takes the request. The response shows
// up in the output register in the cycle after the request is taken; a new
// request is taken while that response waits, as long as the output
// register is free or being drained in the same cycle. The discounted
// drift (drift times theta) is held in a register per lane, so the request
// port pauses after reset and after each csr write while that register
// reloads. Once a trial is decided or timed out, requests without
// trial_start change nothing and report the frozen result.
module attentional_drift_accumulator_core #(
   parameter int NUM_ITEMS = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   adda_req_if.sink                         req,
   adda_rsp_if.source                       rsp,
   input  wire logic                        csr_we,
   input  wire adda_pkg::csr_addr_type      csr_addr,
   input  wire logic [adda_pkg::CNT_W-1:0]  csr_wdata
);
   import adda_pkg::*;

   localparam int LW = $clog2(NUM_ITEMS);

   // settings
   logic signed [DRIFT_W-1:0] drift_ff [NUM_PORTS];
   logic [THETA_W-1:0]        theta_ff;
   logic [CNT_W-1:0]          max_dur_ff;
   logic [CNT_W-1:0]          barrier_ff;
   logic                      settle_ff;

   // trial state
   logic [CNT_W-1:0] elapsed_ff, elapsed_cur, elapsed_in;
   logic [FIX_W-1:0] fixcnt_ff, fixcnt_cur, fixcnt_in;
   logic             finished_ff, finished_in, finished_cur;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      done_ff, timed_ff, chosen_ff;
   logic [1:0]                choice_ff;
   logic [CNT_W-1:0]          rt_ff;
   logic [FIX_W-1:0]          fixations_ff;
   logic signed [DRIFT_W-1:0] fix_drift_ff, fix_drift;
   logic [CNT_W-1:0]          dwell_ff [NUM_PORTS];

   logic                      accept;
   lane_ctrl_type             lane_ctrl;
   logic signed [DRIFT_W-1:0] noise_vec [NUM_PORTS];
   logic signed [EVID_W-1:0]  ev_next [NUM_ITEMS];
   logic [CNT_W-1:0]          dwell_next [NUM_ITEMS];
   logic [CNT_W-1:0]          dwell_out [NUM_PORTS];
   logic [LW-1:0]             leader;
   logic                      decided, timed, fix_valid, chosen;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PORTS; i++) begin
            drift_ff[i] <= '0;
         end
         theta_ff   <= THETA_RESET;
         max_dur_ff <= MAX_DUR_RESET;
         barrier_ff <= BARRIER_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DRIFT_A: drift_ff[0] <= csr_wdata;
            CSR_DRIFT_B: drift_ff[1] <= csr_wdata;
            CSR_DRIFT_C: drift_ff[2] <= csr_wdata;
            CSR_DRIFT_D: drift_ff[3] <= csr_wdata;
            CSR_THETA:   theta_ff    <= csr_wdata[THETA_W-1:0];
            CSR_MAX_DUR: max_dur_ff  <= csr_wdata;
            CSR_BARRIER: barrier_ff  <= csr_wdata;
            default: ;   // unmapped index, ignored
         endcase
      end
   end

   // pause while the lanes reload their discounted drift
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 1'b1;
      end else begin
         settle_ff <= csr_we;
      end
   end

   // ---------------------------------------------------------- handshake
   assign req.ready    = !settle_ff && (!rsp_valid_ff || rsp.ready);
   assign accept       = req.valid && req.ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   // trial start clears everything before this millisecond
   assign finished_cur = !req.trial_start && finished_ff;
   assign elapsed_cur  = req.trial_start ? '0 : elapsed_ff;
   assign fixcnt_cur   = req.trial_start ? '0 : fixcnt_ff;

   assign lane_ctrl.accept = accept;
   assign lane_ctrl.clear  = req.trial_start;
   assign lane_ctrl.hold   = finished_cur;

   assign noise_vec[0] = req.noise_a;
   assign noise_vec[1] = req.noise_b;
   assign noise_vec[2] = req.noise_c;
   assign noise_vec[3] = req.noise_d;

   // -------------------------------------------------------------- lanes
   // lanes past the four on the ports run with zero drift and zero noise
   for (genvar g = 0; g < NUM_ITEMS; g++) begin : g_lane
      logic signed [DRIFT_W-1:0] lane_drift, lane_noise;
      if (g < NUM_PORTS) begin : g_port
         assign lane_drift = drift_ff[g];
         assign lane_noise = noise_vec[g];
      end else begin : g_extra
         assign lane_drift = '0;
         assign lane_noise = '0;
      end

      adda_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .fixated    (32'(req.fix_item) == g),
         .drift      (lane_drift),
         .theta      (theta_ff),
         .noise      (lane_noise),
         .ev_next    (ev_next[g]),
         .dwell_next (dwell_next[g])
      );
   end

   adda_merge #(
      .NUM_ITEMS (NUM_ITEMS)
   ) u_merge (
      .ev      (ev_next),
      .barrier (barrier_ff),
      .leader  (leader),
      .decided (decided)
   );

   // ------------------------------------------------------ trial counters
   assign elapsed_in = (!finished_cur && elapsed_cur != CNT_MAX) ?
                       elapsed_cur + CNT_W'(1) : elapsed_cur;
   assign fixcnt_in  = (!finished_cur && req.fix_first && fixcnt_cur != FIX_MAX) ?
                       fixcnt_cur + FIX_W'(1) : fixcnt_cur;

   // a finished trial stays timed out unless its frozen lead meets the barrier
   assign timed = !decided &&
                  (finished_cur || (req.fix_last && elapsed_in >= max_dur_ff));
   assign finished_in = finished_cur || decided || timed;

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff  <= '0;
         fixcnt_ff   <= '0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         elapsed_ff  <= elapsed_in;
         fixcnt_ff   <= fixcnt_in;
         finished_ff <= finished_in;
      end
   end

   // fixated item outside the race reports no drift and no choice
   assign fix_valid = 32'(req.fix_item) < NUM_ITEMS;
   assign chosen    = fix_valid && (32'(req.fix_item) == 32'(leader));
   assign fix_drift = fix_valid ? drift_ff[req.fix_item] : '0;

   for (genvar g = 0; g < NUM_PORTS; g++) begin : g_dwell
      if (g < NUM_ITEMS) begin : g_live
         assign dwell_out[g] = dwell_next[g];
      end else begin : g_none
         assign dwell_out[g] = '0;
      end
   end

   // ----------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff      <= decided || timed;
         timed_ff     <= timed;
         choice_ff    <= 2'(leader);
         rt_ff        <= timed ? max_dur_ff : elapsed_in;
         fixations_ff <= fixcnt_in;
         chosen_ff    <= chosen;
         fix_drift_ff <= fix_drift;
         for (int i = 0; i < NUM_PORTS; i++) begin
            dwell_ff[i] <= dwell_out[i];
         end
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.done_res            = done_ff;
   assign rsp.timed_out           = timed_ff;
   assign rsp.choice              = choice_ff;
   assign rsp.rt_ms               = rt_ff;
   assign rsp.fixations           = fixations_ff;
   assign rsp.last_fixated_chosen = chosen_ff;
   assign rsp.last_fixated_drift  = fix_drift_ff;
   assign rsp.dwell_a             = dwell_ff[0];
   assign rsp.dwell_b             = dwell_ff[1];
   assign rsp.dwell_c             = dwell_ff[2];
   assign rsp.dwell_d             = dwell_ff[3];

endmodule

`default_nettype wire

/* design/adda_checker.sv */
// port-level checks of the accumulator core, bound to the top level
// depends on assert_macros.svh and attentional_drift_accumulator_core
`default_nettype none

`include "assert_macros.svh"

module adda_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        csr_we,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_done_res,
   input wire logic        rsp_timed_out,
   input wire logic [15:0] rsp_rt_ms
);

   // every request lands in the response register next cycle
   `ADDA_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid, "request lost")

   // a timeout is always a finished trial
   `ADDA_ASSERT_SAME(a_timeout_done, clock, reset, rsp_valid && rsp_timed_out, rsp_done_res, "timeout without done")

   // request port pauses while the lanes reload after a csr write
   `ADDA_ASSERT_NEXT(a_csr_settle, clock, reset, csr_we, !req_ready, "request taken during settle")

   // stalled response keeps its reaction time
   `ADDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rt_ms), "stalled response changed")

endmodule

bind attentional_drift_accumulator_core adda_checker u_adda_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .csr_we        (csr_we),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_done_res  (rsp.done_res),
   .rsp_timed_out (rsp.timed_out),
   .rsp_rt_ms     (rsp.rt_ms)
);

`default_nettype wire
